>>> hw/rtl/rmsn_pkg.sv
package rmsn_pkg;

    // Vector length limit and Newton step count of the inverse square root.
    localparam int MAX_LEN          = 4096;
    localparam int RSQRT_ITERATIONS = 4;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int EPS_W    = 16;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int INV_W    = 32;

    // Inverse square root datapath.
    localparam int MEAN_W      = 31;
    localparam int SHIFT_W     = 4;
    localparam int SHAMT_W     = 5;
    localparam int ITER_W      = $clog2(RSQRT_ITERATIONS);
    localparam int DIV_STEP_W  = $clog2(SUM_W);
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int P_SHIFT     = 28;
    localparam int P_W         = PROD_W - P_SHIFT;
    localparam int RSQRT_OUT_SHIFT = 22;

    localparam logic [MUL_W-1:0] Z_SEED_LOW   = 32'hA000_0000;
    localparam logic [MUL_W-1:0] Z_SEED_HIGH  = 32'h7000_0000;
    localparam logic [P_W-1:0]   NEWTON_THREE = P_W'(64'h3_0000_0000);

    // Normalize datapath.
    localparam int ROUND_SHIFT = 28;
    localparam int MAG_W       = PROD_W - ROUND_SHIFT;
    localparam logic [PROD_W-1:0]   ROUND_HALF  = PROD_W'(64'h0800_0000);
    localparam logic [MAG_W-1:0]    MAG_MAX_POS = MAG_W'(32767);
    localparam logic [MAG_W-1:0]    MAG_MAX_NEG = MAG_W'(32768);
    localparam logic [GAIN_W:0]     GAIN_ONE    = 17'd4096;
    localparam logic [INV_W-1:0]    INV_ONE     = 32'h0001_0000;
    localparam logic [EPS_W-1:0]    EPS_RESET   = 16'd1;

    // Queues.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // A classified input word: magnitudes and signs split off up front.
    typedef struct packed {
        logic                normalize;
        logic                last;
        logic                x_neg;
        logic [SAMPLE_W-1:0] x_mag;
        logic                g_neg;
        logic [GAIN_W-1:0]   g_mag;
    } cmd_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] element_count;
    } inv_req_t;

    typedef struct packed {
        logic             done;
        logic [INV_W-1:0] inverse_rms;
    } inv_rsp_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] normalized;
        logic                clipped;
        logic                end_of_vector;
    } result_t;

    typedef enum logic [3:0] {
        INV_IDLE,
        INV_DIV,
        INV_ADD,
        INV_NORM,
        INV_NQ,
        INV_NP,
        INV_NF,
        INV_NZ,
        INV_FIN,
        INV_OUT
    } inv_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROUND,
        BK_INV
    } back_state_t;

endpackage

>>> hw/rtl/rmsn_front.sv
module rmsn_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                action,
    input  logic signed [rmsn_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [rmsn_pkg::GAIN_W-1:0]  gain_weight,
    input  logic                                last_element,
    output rmsn_pkg::cmd_t                      cmd,
    output logic                                cmd_valid,
    input  logic                                cmd_pop
);

    rmsn_pkg::cmd_t                        cmdq_mem [rmsn_pkg::CMDQ_DEPTH];
    logic [rmsn_pkg::CMDQ_PTR_W-1:0]       wr_ptr_reg;
    logic [rmsn_pkg::CMDQ_PTR_W-1:0]       wr_ptr_next;
    logic [rmsn_pkg::CMDQ_PTR_W-1:0]       rd_ptr_reg;
    logic [rmsn_pkg::CMDQ_PTR_W-1:0]       rd_ptr_next;
    logic [rmsn_pkg::CMDQ_CNT_W-1:0]       count_reg;
    logic [rmsn_pkg::CMDQ_CNT_W-1:0]       count_next;
    logic                                  push_ok;
    logic [rmsn_pkg::GAIN_W:0]             gain_ofs;
    rmsn_pkg::cmd_t                        cmd_in;

    // The gain is 1 + w, so offset the Q4.12 weight by one.
    assign gain_ofs = {gain_weight[rmsn_pkg::GAIN_W-1], gain_weight} + rmsn_pkg::GAIN_ONE;

    always_comb
    begin
        cmd_in.normalize = action;
        cmd_in.last      = last_element;
        cmd_in.x_neg     = sample[rmsn_pkg::SAMPLE_W-1];
        cmd_in.x_mag     = sample[rmsn_pkg::SAMPLE_W-1] ?
                           rmsn_pkg::SAMPLE_W'(~sample + 1'b1) : sample;
        cmd_in.g_neg     = gain_ofs[rmsn_pkg::GAIN_W];
        cmd_in.g_mag     = gain_ofs[rmsn_pkg::GAIN_W] ?
                           rmsn_pkg::GAIN_W'(~gain_ofs + 1'b1) :
                           gain_ofs[rmsn_pkg::GAIN_W-1:0];
    end

    assign full      = (count_reg == rmsn_pkg::CMDQ_CNT_W'(rmsn_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push_ok   = push & ~full;
    assign cmd       = cmdq_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == rmsn_pkg::CMDQ_PTR_W'(rmsn_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rmsn_pkg::CMDQ_PTR_W'(rmsn_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            cmdq_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> hw/rtl/rmsn_inv_rms.sv
module rmsn_inv_rms (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rmsn_pkg::EPS_W-1:0]     epsilon,
    input  rmsn_pkg::inv_req_t             req,
    output rmsn_pkg::inv_rsp_t             rsp
);

    rmsn_pkg::inv_state_t                  state_reg;
    rmsn_pkg::inv_state_t                  state_next;
    logic [rmsn_pkg::SUM_W-1:0]            num_reg;
    logic [rmsn_pkg::SUM_W-1:0]            num_next;
    logic [rmsn_pkg::CNT_W-1:0]            den_reg;
    logic [rmsn_pkg::CNT_W-1:0]            den_next;
    logic [rmsn_pkg::CNT_W-1:0]            rem_reg;
    logic [rmsn_pkg::CNT_W-1:0]            rem_next;
    logic [rmsn_pkg::DIV_STEP_W-1:0]       step_reg;
    logic [rmsn_pkg::DIV_STEP_W-1:0]       step_next;
    logic [rmsn_pkg::MEAN_W-1:0]           m_reg;
    logic [rmsn_pkg::MEAN_W-1:0]           m_next;
    logic [rmsn_pkg::SHIFT_W-1:0]          s_reg;
    logic [rmsn_pkg::SHIFT_W-1:0]          s_next;
    logic [rmsn_pkg::MUL_W-1:0]            z_reg;
    logic [rmsn_pkg::MUL_W-1:0]            z_next;
    logic [rmsn_pkg::MUL_W-1:0]            q_reg;
    logic [rmsn_pkg::MUL_W-1:0]            q_next;
    logic [rmsn_pkg::P_W-1:0]              p_reg;
    logic [rmsn_pkg::P_W-1:0]              p_next;
    logic [rmsn_pkg::MUL_W-1:0]            f_reg;
    logic [rmsn_pkg::MUL_W-1:0]            f_next;
    logic [rmsn_pkg::ITER_W-1:0]           iter_reg;
    logic [rmsn_pkg::ITER_W-1:0]           iter_next;
    logic [rmsn_pkg::INV_W-1:0]            inv_reg;
    logic [rmsn_pkg::INV_W-1:0]            inv_next;

    logic [rmsn_pkg::CNT_W:0]              r_shift;
    logic [rmsn_pkg::CNT_W:0]              r_diff;
    logic                                  r_ge;
    logic [rmsn_pkg::SUM_W-1:0]            mean;
    logic [rmsn_pkg::SUM_W:0]              v_sum;
    logic [rmsn_pkg::P_W-1:0]              f_diff;
    logic [rmsn_pkg::SHAMT_W-1:0]          shamt;
    logic [rmsn_pkg::MUL_W-1:0]            mul_a;
    logic [rmsn_pkg::MUL_W-1:0]            mul_b;
    logic [rmsn_pkg::PROD_W-1:0]           mul_prod;

    // Restoring division step: one quotient bit per cycle, shifted into num_reg.
    assign r_shift = {rem_reg, num_reg[rmsn_pkg::SUM_W-1]};
    assign r_diff  = r_shift - {1'b0, den_reg};
    assign r_ge    = (r_shift >= {1'b0, den_reg});

    assign mean   = (den_reg == '0) ? '0 : num_reg;
    assign v_sum  = {1'b0, mean} + (rmsn_pkg::SUM_W + 1)'(epsilon);
    assign f_diff = rmsn_pkg::NEWTON_THREE - p_reg;
    assign shamt  = rmsn_pkg::SHAMT_W'(rmsn_pkg::RSQRT_OUT_SHIFT) - rmsn_pkg::SHAMT_W'(s_reg);

    // One multiplier serves the three products of each Newton step.
    always_comb
    begin
        case (state_reg)
            rmsn_pkg::INV_NP:
            begin
                mul_a = rmsn_pkg::MUL_W'(m_reg);
                mul_b = q_reg;
            end
            rmsn_pkg::INV_NZ:
            begin
                mul_a = z_reg;
                mul_b = f_reg;
            end
            default:
            begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
        endcase
    end

    assign mul_prod = {{rmsn_pkg::MUL_W{1'b0}}, mul_a} * {{rmsn_pkg::MUL_W{1'b0}}, mul_b};

    always_comb
    begin
        state_next      = state_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        m_next          = m_reg;
        s_next          = s_reg;
        z_next          = z_reg;
        q_next          = q_reg;
        p_next          = p_reg;
        f_next          = f_reg;
        iter_next       = iter_reg;
        inv_next        = inv_reg;
        rsp.done        = 1'b0;
        rsp.inverse_rms = inv_reg;
        case (state_reg)
            rmsn_pkg::INV_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = req.square_sum;
                    den_next   = req.element_count;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = rmsn_pkg::INV_DIV;
                end
            end
            rmsn_pkg::INV_DIV:
            begin
                rem_next  = r_ge ? r_diff[rmsn_pkg::CNT_W-1:0] : r_shift[rmsn_pkg::CNT_W-1:0];
                num_next  = {num_reg[rmsn_pkg::SUM_W-2:0], r_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == rmsn_pkg::DIV_STEP_W'(rmsn_pkg::SUM_W - 1))
                begin
                    state_next = rmsn_pkg::INV_ADD;
                end
            end
            rmsn_pkg::INV_ADD:
            begin
                m_next = v_sum[rmsn_pkg::MEAN_W-1:0];
                s_next = '0;
                if (v_sum == '0)
                begin
                    // A zero mean square with a zero stabilizer saturates.
                    inv_next   = '1;
                    state_next = rmsn_pkg::INV_OUT;
                end
                else
                begin
                    state_next = rmsn_pkg::INV_NORM;
                end
            end
            rmsn_pkg::INV_NORM:
            begin
                if (m_reg[rmsn_pkg::MEAN_W-1 -: 2] == 2'b00)
                begin
                    m_next = {m_reg[rmsn_pkg::MEAN_W-3:0], 2'b00};
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    z_next     = m_reg[rmsn_pkg::MEAN_W-1] ?
                                 rmsn_pkg::Z_SEED_HIGH : rmsn_pkg::Z_SEED_LOW;
                    iter_next  = '0;
                    state_next = rmsn_pkg::INV_NQ;
                end
            end
            rmsn_pkg::INV_NQ:
            begin
                q_next     = mul_prod[rmsn_pkg::PROD_W-1:rmsn_pkg::MUL_W];
                state_next = rmsn_pkg::INV_NP;
            end
            rmsn_pkg::INV_NP:
            begin
                p_next     = mul_prod[rmsn_pkg::PROD_W-1:rmsn_pkg::P_SHIFT];
                state_next = rmsn_pkg::INV_NF;
            end
            rmsn_pkg::INV_NF:
            begin
                f_next     = (p_reg >= rmsn_pkg::NEWTON_THREE) ?
                             '0 : f_diff[rmsn_pkg::MUL_W+1:2];
                state_next = rmsn_pkg::INV_NZ;
            end
            rmsn_pkg::INV_NZ:
            begin
                z_next    = mul_prod[rmsn_pkg::PROD_W-2:rmsn_pkg::MUL_W-1];
                iter_next = iter_reg + 1'b1;
                if (iter_reg == rmsn_pkg::ITER_W'(rmsn_pkg::RSQRT_ITERATIONS - 1))
                begin
                    state_next = rmsn_pkg::INV_FIN;
                end
                else
                begin
                    state_next = rmsn_pkg::INV_NQ;
                end
            end
            rmsn_pkg::INV_FIN:
            begin
                inv_next   = z_reg >> shamt;
                state_next = rmsn_pkg::INV_OUT;
            end
            rmsn_pkg::INV_OUT:
            begin
                rsp.done   = 1'b1;
                state_next = rmsn_pkg::INV_IDLE;
            end
            default:
            begin
                state_next = rmsn_pkg::INV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmsn_pkg::INV_IDLE;
            step_reg  <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        m_reg   <= m_next;
        s_reg   <= s_next;
        z_reg   <= z_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
        f_reg   <= f_next;
        inv_reg <= inv_next;
    end

endmodule

>>> hw/rtl/rmsn_back.sv
module rmsn_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmsn_pkg::cmd_t                     cmd,
    input  logic                               cmd_valid,
    output logic                               cmd_pop,
    output rmsn_pkg::inv_req_t                 inv_req,
    input  rmsn_pkg::inv_rsp_t                 inv_rsp,
    output logic                               empty,
    input  logic                               pop,
    output logic [rmsn_pkg::SAMPLE_W-1:0]      normalized,
    output logic                               clipped,
    output logic                               end_of_vector
);

    rmsn_pkg::back_state_t                 state_reg;
    rmsn_pkg::back_state_t                 state_next;
    logic [rmsn_pkg::SUM_W-1:0]            sum_reg;
    logic [rmsn_pkg::SUM_W-1:0]            sum_next;
    logic [rmsn_pkg::CNT_W-1:0]            count_reg;
    logic [rmsn_pkg::CNT_W-1:0]            count_next;
    logic                                  ovf_reg;
    logic                                  ovf_next;
    logic [rmsn_pkg::INV_W-1:0]            inv_reg;
    logic [rmsn_pkg::INV_W-1:0]            inv_next;
    logic [rmsn_pkg::MUL_W-1:0]            xg_reg;
    logic [rmsn_pkg::MUL_W-1:0]            xg_next;
    logic [rmsn_pkg::PROD_W-1:0]           prod_reg;
    logic [rmsn_pkg::PROD_W-1:0]           prod_next;
    logic                                  neg_reg;
    logic                                  neg_next;
    logic                                  last_reg;
    logic                                  last_next;

    rmsn_pkg::result_t                     resq_mem [rmsn_pkg::RESQ_DEPTH];
    logic [rmsn_pkg::RESQ_PTR_W-1:0]       res_wr_ptr_reg;
    logic [rmsn_pkg::RESQ_PTR_W-1:0]       res_rd_ptr_reg;
    logic [rmsn_pkg::RESQ_CNT_W-1:0]       res_count_reg;
    logic                                  res_push;
    logic                                  res_pop;
    rmsn_pkg::result_t                     res_in;

    logic [rmsn_pkg::MUL_W-1:0]            sq;
    logic [rmsn_pkg::SUM_W-1:0]            sum_upd;
    logic [rmsn_pkg::CNT_W-1:0]            count_upd;
    logic                                  ovf_upd;
    logic [rmsn_pkg::PROD_W-1:0]           rnd;
    logic [rmsn_pkg::MAG_W-1:0]            mag;
    logic                                  neg_eff;
    logic [rmsn_pkg::SAMPLE_W-1:0]         mag_sat;
    logic                                  sat;

    assign sq = {{rmsn_pkg::SAMPLE_W{1'b0}}, cmd.x_mag} *
                {{rmsn_pkg::SAMPLE_W{1'b0}}, cmd.x_mag};

    // Accumulate update; the overflow flag restarts with each new pass.
    always_comb
    begin
        if (count_reg >= rmsn_pkg::CNT_W'(rmsn_pkg::MAX_LEN))
        begin
            sum_upd   = sum_reg;
            count_upd = count_reg;
            ovf_upd   = 1'b1;
        end
        else
        begin
            sum_upd   = sum_reg + rmsn_pkg::SUM_W'(sq);
            count_upd = count_reg + 1'b1;
            ovf_upd   = (count_reg == '0) ? 1'b0 : ovf_reg;
        end
    end

    // Round half away from zero on the magnitude, then saturate.
    assign rnd     = prod_reg + rmsn_pkg::ROUND_HALF;
    assign mag     = rnd[rmsn_pkg::PROD_W-1:rmsn_pkg::ROUND_SHIFT];
    assign neg_eff = neg_reg & (mag != '0);

    always_comb
    begin
        if (!neg_eff && (mag > rmsn_pkg::MAG_MAX_POS))
        begin
            mag_sat = rmsn_pkg::MAG_MAX_POS[rmsn_pkg::SAMPLE_W-1:0];
            sat     = 1'b1;
        end
        else if (neg_eff && (mag > rmsn_pkg::MAG_MAX_NEG))
        begin
            mag_sat = rmsn_pkg::MAG_MAX_NEG[rmsn_pkg::SAMPLE_W-1:0];
            sat     = 1'b1;
        end
        else
        begin
            mag_sat = mag[rmsn_pkg::SAMPLE_W-1:0];
            sat     = 1'b0;
        end
        res_in.normalized    = neg_eff ? (~mag_sat + 1'b1) : mag_sat;
        res_in.clipped       = sat | ovf_reg;
        res_in.end_of_vector = last_reg;
    end

    always_comb
    begin
        state_next            = state_reg;
        sum_next              = sum_reg;
        count_next            = count_reg;
        ovf_next              = ovf_reg;
        inv_next              = inv_reg;
        xg_next               = xg_reg;
        prod_next             = prod_reg;
        neg_next              = neg_reg;
        last_next             = last_reg;
        cmd_pop               = 1'b0;
        inv_req.start         = 1'b0;
        inv_req.square_sum    = sum_upd;
        inv_req.element_count = count_upd;
        res_push              = 1'b0;
        case (state_reg)
            rmsn_pkg::BK_IDLE:
            begin
                if (cmd_valid && !cmd.normalize)
                begin
                    cmd_pop    = 1'b1;
                    ovf_next   = ovf_upd;
                    sum_next   = sum_upd;
                    count_next = count_upd;
                    if (cmd.last)
                    begin
                        inv_req.start = 1'b1;
                        sum_next      = '0;
                        count_next    = '0;
                        state_next    = rmsn_pkg::BK_INV;
                    end
                end
                else if (cmd_valid &&
                         (res_count_reg != rmsn_pkg::RESQ_CNT_W'(rmsn_pkg::RESQ_DEPTH)))
                begin
                    cmd_pop    = 1'b1;
                    xg_next    = {{rmsn_pkg::SAMPLE_W{1'b0}}, cmd.x_mag} *
                                 {{rmsn_pkg::GAIN_W{1'b0}}, cmd.g_mag};
                    neg_next   = cmd.x_neg ^ cmd.g_neg;
                    last_next  = cmd.last;
                    state_next = rmsn_pkg::BK_MUL;
                end
            end
            rmsn_pkg::BK_MUL:
            begin
                prod_next  = {{rmsn_pkg::MUL_W{1'b0}}, xg_reg} *
                             {{(rmsn_pkg::PROD_W - rmsn_pkg::INV_W){1'b0}}, inv_reg};
                state_next = rmsn_pkg::BK_ROUND;
            end
            rmsn_pkg::BK_ROUND:
            begin
                res_push   = 1'b1;
                state_next = rmsn_pkg::BK_IDLE;
            end
            rmsn_pkg::BK_INV:
            begin
                if (inv_rsp.done)
                begin
                    inv_next   = inv_rsp.inverse_rms;
                    state_next = rmsn_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rmsn_pkg::BK_IDLE;
            end
        endcase
    end

    assign empty         = (res_count_reg == '0);
    assign res_pop       = pop & ~empty;
    assign normalized    = resq_mem[res_rd_ptr_reg].normalized;
    assign clipped       = resq_mem[res_rd_ptr_reg].clipped;
    assign end_of_vector = resq_mem[res_rd_ptr_reg].end_of_vector;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rmsn_pkg::BK_IDLE;
            sum_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            inv_reg        <= rmsn_pkg::INV_ONE;
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            inv_reg   <= inv_next;
            if (res_push)
            begin
                res_wr_ptr_reg <=
                    (res_wr_ptr_reg == rmsn_pkg::RESQ_PTR_W'(rmsn_pkg::RESQ_DEPTH - 1)) ?
                    '0 : res_wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <=
                    (res_rd_ptr_reg == rmsn_pkg::RESQ_PTR_W'(rmsn_pkg::RESQ_DEPTH - 1)) ?
                    '0 : res_rd_ptr_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                res_count_reg <= res_count_reg + 1'b1;
            end
            else if (!res_push && res_pop)
            begin
                res_count_reg <= res_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xg_reg   <= xg_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        last_reg <= last_next;
        if (res_push)
        begin
            resq_mem[res_wr_ptr_reg] <= res_in;
        end
    end

endmodule

>>> hw/rtl/rms_norm_offset_gain.sv
// RMS normalization with zero-centered gain, y = x * rsqrt(mean(x^2) + epsilon) * (1 + w).
// Samples are signed Q8.8, weights signed Q4.12, epsilon is in Q16.16 units. Each vector
// is sent twice: words with action 0 accumulate squares, and the word marked last_element
// computes the inverse RMS; words with action 1 each produce one rounded, saturated result
// word. Up to 4096 elements are summed per pass; further accumulate words are dropped and
// set clipped on every result of the following normalize pass. Input words go into a
// four-entry queue, so pushes are taken while the back end works. A normalize word passes
// through the two multiply stages and the rounding stage of the scaling path, and the back
// end takes no new word until its result is queued. The word that ends an accumulate pass
// holds the back end through a bit-serial division for the mean, a normalizing shift and
// the Newton steps, which share one 32 by 32 multiplier. A normalize pass before any
// accumulate pass scales by 1.0. Results wait in a two-entry queue and are read with pop
// while empty is low. Write epsilon only while idle.
module rms_norm_offset_gain (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rmsn_pkg::EPS_W-1:0]           cfg_write_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 action,
    input  logic signed [rmsn_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [rmsn_pkg::GAIN_W-1:0]   gain_weight,
    input  logic                                 last_element,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [rmsn_pkg::SAMPLE_W-1:0] normalized,
    output logic                                 clipped,
    output logic                                 end_of_vector
);

    // Stabilizer register, reset to one Q16.16 unit.
    logic [rmsn_pkg::EPS_W-1:0]    epsilon_reg;
    logic [rmsn_pkg::EPS_W-1:0]    epsilon_next;

    // Front to back command queue handshake.
    rmsn_pkg::cmd_t                cmd;
    logic                          cmd_valid;
    logic                          cmd_pop;

    // Inverse RMS request and response.
    rmsn_pkg::inv_req_t            inv_req;
    rmsn_pkg::inv_rsp_t            inv_rsp;

    logic [rmsn_pkg::SAMPLE_W-1:0] normalized_bits;

    assign epsilon_next = cfg_write_en ? cfg_write_data : epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= rmsn_pkg::EPS_RESET;
        end
        else
        begin
            epsilon_reg <= epsilon_next;
        end
    end

    rmsn_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .sample       (sample),
        .gain_weight  (gain_weight),
        .last_element (last_element),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop)
    );

    rmsn_inv_rms u_inv_rms (
        .clk     (clk),
        .rst_n   (rst_n),
        .epsilon (epsilon_reg),
        .req     (inv_req),
        .rsp     (inv_rsp)
    );

    rmsn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .inv_req       (inv_req),
        .inv_rsp       (inv_rsp),
        .empty         (empty),
        .pop           (pop),
        .normalized    (normalized_bits),
        .clipped       (clipped),
        .end_of_vector (end_of_vector)
    );

    assign normalized = normalized_bits;

endmodule

>>> tb/rmsn_checker.sv
`timescale 1ns / 100ps

module rmsn_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rmsn_pkg::EPS_W-1:0]           cfg_write_data,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 action,
    input  logic signed [rmsn_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [rmsn_pkg::GAIN_W-1:0]   gain_weight,
    input  logic                                 last_element,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic signed [rmsn_pkg::SAMPLE_W-1:0] normalized,
    input  logic                                 clipped,
    input  logic                                 end_of_vector,
    output int                                   failures,
    output int                                   outstanding
);

    logic [rmsn_pkg::EPS_W-1:0] eps_reg;
    logic [rmsn_pkg::SUM_W-1:0] sum_sq;
    logic [rmsn_pkg::CNT_W-1:0] elem_cnt;
    logic [rmsn_pkg::INV_W-1:0] inv_rms;
    logic                       len_overflow;
    logic [63:0]                sq_mag;
    logic [63:0]                mean_sq;
    rmsn_pkg::result_t          norm_results_q[$];
    rmsn_pkg::result_t          got;
    rmsn_pkg::result_t          want;
    int                         mismatches = 0;

    // Words still owed by the block count as failures until they arrive.
    assign failures = mismatches + outstanding;

    // Fixed-point inverse square root: about 2^24 / sqrt(v), Newton refined.
    function automatic logic [rmsn_pkg::INV_W-1:0] inverse_sqrt_fix(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] z;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] f;
        logic [63:0] three;
        int          s;
        int          i;
        if (v == 64'd0)
            return '1;
        m = v;
        s = 0;
        three = 64'(rmsn_pkg::NEWTON_THREE);
        while (m < (64'd1 << 29))
        begin
            m = m << 2;
            s++;
        end
        z = (m < (64'd1 << 30)) ? 64'(rmsn_pkg::Z_SEED_LOW) : 64'(rmsn_pkg::Z_SEED_HIGH);
        for (i = 0; i < rmsn_pkg::RSQRT_ITERATIONS; i++)
        begin
            q = (z * z) >> 32;
            p = (m * q) >> 28;
            f = (p >= three) ? 64'd0 : ((three - p) >> 2);
            z = (z * f) >> 31;
        end
        return rmsn_pkg::INV_W'(z >> (rmsn_pkg::RSQRT_OUT_SHIFT - s));
    endfunction

    // Scales one element by the inverse RMS and the offset gain, rounds half away
    // from zero and saturates to the signed Q8.8 range.
    function automatic rmsn_pkg::result_t scale_element(
        input logic signed [rmsn_pkg::SAMPLE_W-1:0] x,
        input logic signed [rmsn_pkg::GAIN_W-1:0]   w,
        input logic                                 lst,
        input logic [rmsn_pkg::INV_W-1:0]           inv,
        input logic                                 ovf
    );
        int                xi;
        int                gain;
        logic              neg;
        logic              sat;
        logic [63:0]       xm;
        logic [63:0]       gm;
        logic [63:0]       mag;
        rmsn_pkg::result_t r;
        xi = int'(x);
        gain = int'(w) + int'(rmsn_pkg::GAIN_ONE);
        neg = (xi < 0) != (gain < 0);
        xm = (xi < 0) ? 64'(-xi) : 64'(xi);
        gm = (gain < 0) ? 64'(-gain) : 64'(gain);
        mag = (xm * 64'(inv) * gm + 64'(rmsn_pkg::ROUND_HALF)) >> rmsn_pkg::ROUND_SHIFT;
        sat = 1'b0;
        if (mag == 64'd0)
            neg = 1'b0;
        if (!neg && mag > 64'd32767)
        begin
            mag = 64'd32767;
            sat = 1'b1;
        end
        else if (neg && mag > 64'd32768)
        begin
            mag = 64'd32768;
            sat = 1'b1;
        end
        r.normalized = neg ? 16'(64'd0 - mag) : 16'(mag);
        r.clipped = sat || ovf;
        r.end_of_vector = lst;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            eps_reg = rmsn_pkg::EPS_RESET;
            sum_sq = '0;
            elem_cnt = '0;
            inv_rms = rmsn_pkg::INV_ONE;
            len_overflow = 1'b0;
            norm_results_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
                eps_reg = cfg_write_data;

            if (pop && !empty)
            begin
                got.normalized = normalized;
                got.clipped = clipped;
                got.end_of_vector = end_of_vector;
                if (norm_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word: normalized %0d clipped %0b eov %0b",
                             $time, normalized, clipped, end_of_vector);
                end
                else
                begin
                    want = norm_results_q.pop_front();
                    if (got.normalized !== want.normalized || got.clipped !== want.clipped ||
                        got.end_of_vector !== want.end_of_vector)
                    begin
                        mismatches++;
                        $display("%0t: expected normalized %0d clipped %0b eov %0b, got %0d %0b %0b",
                                 $time, $signed(want.normalized), want.clipped,
                                 want.end_of_vector, normalized, clipped, end_of_vector);
                    end
                end
            end

            if (push && !full)
            begin
                if (action)
                begin
                    norm_results_q.insert(norm_results_q.size(),
                                          scale_element(sample, gain_weight, last_element,
                                                        inv_rms, len_overflow));
                end
                else
                begin
                    if (elem_cnt == '0)
                        len_overflow = 1'b0;
                    if (elem_cnt >= rmsn_pkg::MAX_LEN)
                        len_overflow = 1'b1;
                    else
                    begin
                        sq_mag = (sample < 0) ? 64'(-int'(sample)) : 64'(int'(sample));
                        sum_sq = sum_sq + rmsn_pkg::SUM_W'(sq_mag * sq_mag);
                        elem_cnt = elem_cnt + 1'b1;
                    end
                    if (last_element)
                    begin
                        mean_sq = (elem_cnt == '0) ? 64'd0 : 64'(sum_sq) / 64'(elem_cnt);
                        inv_rms = inverse_sqrt_fix(mean_sq + 64'(eps_reg));
                        sum_sq = '0;
                        elem_cnt = '0;
                    end
                end
            end

            outstanding <= norm_results_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // Action codes of an input word.
    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_NORMALIZE  = 1'b1;

    localparam logic signed [rmsn_pkg::SAMPLE_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [rmsn_pkg::SAMPLE_W-1:0] VAL_MIN = 16'sh8000;

    // The back end can hold up to five accumulate words that each end a pass, each
    // running the inverse RMS computation, after the last result word has come out.
    localparam int SETTLE_CYCLES = 500;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write_en = 1'b0;
    logic [rmsn_pkg::EPS_W-1:0]           cfg_write_data = '0;
    logic                                 push = 1'b0;
    logic                                 full;
    logic                                 action = 1'b0;
    logic signed [rmsn_pkg::SAMPLE_W-1:0] sample = '0;
    logic signed [rmsn_pkg::GAIN_W-1:0]   gain_weight = '0;
    logic                                 last_element = 1'b0;
    logic                                 empty;
    logic                                 pop = 1'b0;
    logic signed [rmsn_pkg::SAMPLE_W-1:0] normalized;
    logic                                 clipped;
    logic                                 end_of_vector;

    int failures;
    int outstanding;

    // Stimulus controls shared by the sender and the receiver. A burst flag turns
    // off the random gaps of that side; a hold request makes the receiver stop
    // popping for a long stretch.
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_hold_req = 0;
    int words_sent = 0;

    always #5 clk = ~clk;

    rms_norm_offset_gain DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .push          (push),
        .full          (full),
        .action        (action),
        .sample        (sample),
        .gain_weight   (gain_weight),
        .last_element  (last_element),
        .empty         (empty),
        .pop           (pop),
        .normalized    (normalized),
        .clipped       (clipped),
        .end_of_vector (end_of_vector)
    );

    rmsn_checker CHK (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .push          (push),
        .full          (full),
        .action        (action),
        .sample        (sample),
        .gain_weight   (gain_weight),
        .last_element  (last_element),
        .empty         (empty),
        .pop           (pop),
        .normalized    (normalized),
        .clipped       (clipped),
        .end_of_vector (end_of_vector),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // Values for samples and weights: full-range noise, small values near zero,
    // mid-range values and the extremes of the 16-bit field.
    function automatic logic signed [15:0] pick_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 3)
            return 16'($urandom);
        if (pick < 5)
            return 16'(int'($urandom_range(0, 1024)) - 512);
        if (pick < 7)
            return 16'(int'($urandom_range(0, 16384)) - 8192);
        case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Offers one word after a random gap and returns at the clock edge that takes
    // it. With a gap of zero, push simply stays high for the next word.
    task automatic send_word(input logic act, input logic signed [15:0] x,
                             input logic signed [15:0] w, input logic lst);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= act;
        sample <= x;
        gain_weight <= w;
        last_element <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
    endtask

    // Stops offering words and waits until the checker expects no more results.
    // The outstanding count is registered, so it is read after the edge that follows the push.
    task automatic wait_all_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Epsilon is only written with the block idle: all results in, and enough
    // extra cycles for any trailing accumulate words to finish.
    task automatic write_epsilon(input logic [rmsn_pkg::EPS_W-1:0] value);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // One well-formed vector: an accumulate pass closed by last_element, then a
    // normalize pass of the same length, usually over the same samples.
    task automatic send_vector(input int len, input bit same_samples);
        logic signed [15:0] elems[$];
        logic signed [15:0] v;
        int                 i;
        for (i = 0; i < len; i++)
        begin
            v = pick_value();
            elems.insert(elems.size(), v);
            send_word(ACT_ACCUMULATE, v, pick_value(), i == len - 1);
        end
        for (i = 0; i < len; i++)
        begin
            v = same_samples ? elems[i] : pick_value();
            send_word(ACT_NORMALIZE, v, pick_value(), i == len - 1);
        end
    endtask

    // An accumulate pass left open while normalize words come through. Those use
    // the previous inverse RMS, and the partial sum carries into the next pass.
    task automatic send_broken();
        int n_acc;
        int n_norm;
        n_acc = $urandom_range(1, 6);
        n_norm = $urandom_range(1, 4);
        repeat (n_acc) send_word(ACT_ACCUMULATE, pick_value(), pick_value(), 1'b0);
        repeat (n_norm) send_word(ACT_NORMALIZE, pick_value(), pick_value(),
                                  1'($urandom_range(0, 1)));
    endtask

    // Mostly well-formed vectors with random content, some broken passes and
    // some fully random single words.
    task automatic random_phase(input int budget);
        int stop_at;
        int pick;
        int len;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                send_vector(len, $urandom_range(0, 4) != 0);
            end
            else if (pick < 85)
                send_broken();
            else
                send_word(1'($urandom_range(0, 1)), pick_value(), pick_value(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // The receiver waits a random number of cycles before each word it takes, unless its
    // burst flag is set, and adds a long hold-off when one is requested.
    initial
    begin : receiver
        int wait_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 12);
            if (rx_hold_req > 0)
            begin
                wait_cycles += rx_hold_req;
                rx_hold_req = 0;
            end
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int p;
        int i;
        int guard;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Normalize words before any accumulate pass scale by the reset inverse of
        // 1.0: an exact full-scale value, saturation both ways, a zero gain and a
        // negative gain.
        send_word(ACT_NORMALIZE, VAL_MAX, 16'sh0000, 1'b0);
        send_word(ACT_NORMALIZE, VAL_MIN, VAL_MAX, 1'b0);
        send_word(ACT_NORMALIZE, VAL_MAX, VAL_MAX, 1'b0);
        send_word(ACT_NORMALIZE, 16'sh0001, -16'sd4096, 1'b0);
        send_word(ACT_NORMALIZE, 16'shFFFF, VAL_MIN, 1'b1);

        // Extreme samples and weights through a two-element vector.
        send_word(ACT_ACCUMULATE, VAL_MIN, 16'sh0000, 1'b0);
        send_word(ACT_ACCUMULATE, VAL_MAX, 16'sh0000, 1'b1);
        send_word(ACT_NORMALIZE, VAL_MIN, VAL_MIN, 1'b0);
        send_word(ACT_NORMALIZE, VAL_MAX, VAL_MAX, 1'b1);

        // Largest epsilon over an all-zero vector.
        write_epsilon(16'hFFFF);
        send_word(ACT_ACCUMULATE, 16'sh0000, 16'sh0000, 1'b0);
        send_word(ACT_ACCUMULATE, 16'sh0000, 16'sh0000, 1'b1);
        send_word(ACT_NORMALIZE, 16'sh0100, 16'sh0000, 1'b0);
        send_word(ACT_NORMALIZE, -16'sh0100, 16'sh0000, 1'b1);

        // Zero epsilon with a zero sum: the inverse saturates to all ones.
        write_epsilon(16'h0000);
        send_word(ACT_ACCUMULATE, 16'sh0000, 16'sh0000, 1'b0);
        send_word(ACT_ACCUMULATE, 16'sh0000, 16'sh0000, 1'b1);
        send_word(ACT_NORMALIZE, 16'sh0001, 16'sh0000, 1'b0);
        send_word(ACT_NORMALIZE, 16'sh0000, 16'sh0000, 1'b1);

        // Back to the reset value, with a single-element vector.
        write_epsilon(rmsn_pkg::EPS_RESET);
        send_word(ACT_ACCUMULATE, 16'sh0001, 16'sh0000, 1'b1);
        send_word(ACT_NORMALIZE, 16'sh0001, 16'sh0000, 1'b1);

        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: write_epsilon(16'($urandom_range(1, 65535)));
                1: write_epsilon(16'($urandom_range(1, 64)));
                2: write_epsilon(16'hFFFF);
                default: write_epsilon(16'h0001);
            endcase
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);

            if (p == 2)
            begin
                // The receiver stops for a long stretch while words keep coming
                // back to back, so both queues fill and full stalls the sender.
                tx_burst = 1'b1;
                rx_burst = 1'b0;
                rx_hold_req = HOLD_CYCLES;
                repeat (30) send_word(ACT_NORMALIZE, pick_value(), pick_value(), 1'b0);
                tx_burst = 1'b0;
            end

            if (p == 5)
            begin
                // The sender pauses in the middle of a phase until all results are in.
                random_phase(110);
                wait_all_results();
                random_phase(110);
            end
            else
                random_phase(230);
        end

        // Too many elements: the pass reaches the length limit, further accumulate
        // words are dropped, and the last of them still closes the pass. Every
        // result of the next normalize pass carries the clipped flag.
        tx_burst = 1'b1;
        for (i = 0; i < rmsn_pkg::MAX_LEN + 2; i++)
            send_word(ACT_ACCUMULATE, pick_value(), pick_value(), i == rmsn_pkg::MAX_LEN + 1);
        tx_burst = 1'b0;
        for (i = 0; i < 8; i++)
            send_word(ACT_NORMALIZE, pick_value(), pick_value(), i == 7);

        // The first accumulate word of the next pass clears the overflow flag.
        send_vector(3, 1'b1);

        push <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
